### rtl/rrfd_pkg.sv
package rrfd_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int FRAME_TOTAL  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int STORE_DEPTH  = 4096;
	localparam int ADDR_W       = 12;

	localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
	localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
	localparam int DONE_W = $clog2(FRAME_TOTAL + 1);
	localparam int LIN_W  = (DONE_W > ADDR_W) ? DONE_W : ADDR_W + 1;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic OP_PACKET   = 1'b0;
	localparam logic OP_READ     = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	typedef enum logic [0:0] {
		REG_COLUMN_CODE = 1'b0,
		REG_ROW_CODE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SCAN_NONE   = 2'd0,
		SCAN_COLUMN = 2'd1,
		SCAN_ROW    = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic              op;
		logic [7:0]        data_byte;
		logic              last_byte;
		logic [ADDR_W-1:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] packet_id;
		logic [7:0] packet_flag;
		logic       frame_ok;
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
	} result_t;

	typedef struct packed {
		logic              do_read;
		logic              do_run;
		logic              do_status;
		scan_mode_t        mode;
		logic [7:0]        run_count;
		logic [23:0]       rgb;
		logic [7:0]        packet_id;
		logic [7:0]        packet_flag;
		logic [ADDR_W-1:0] read_address;
	} cmd_t;

endpackage

### rtl/rle_rgb_frame_decoder.sv
// channel   handshake             payload
// item      push / full           in_item_t: op, data_byte, last_byte, read_address
// result    pop / empty           result_t: kind, id, flag, ok, red, green, blue
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data (0 column code, 1 row code)
//
// Packet bytes that do not end a quad or a packet are accepted while the
// command queue (4 deep) has room. For a complete quad the back end writes
// min(count, pixels left) pixels, one frame store write per cycle.
// Status results and pixel reads leave from the back end's finish and read
// states; read data comes from the registered store port. Results wait in a
// 2-entry output queue; the front keeps taking beats while the command queue has room.
// Reset clears control only, the frame store holds whatever was last written.
module rle_rgb_frame_decoder import rrfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   item,
	output logic       empty,
	input  logic       pop,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_reg_t   cfg_index,
	input  logic [7:0] cfg_data
);

	logic cmd_push, cmd_full, cmd_valid, cmd_pop;
	cmd_t cmd_in, cmd_head;

	assign full      = cmd_full;
	assign cfg_ready = 1'b1;

	rrfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !cmd_full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	rrfd_cmd_fifo u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.valid     (cmd_valid),
		.head      (cmd_head)
	);

	rrfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

### rtl/rrfd_front.sv
module rrfd_front import rrfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_item_t    item,
	input  logic        cfg_valid,
	input  cfg_reg_t    cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        cmd_push,
	output cmd_t        cmd
);

	typedef enum logic [2:0] {
		PH_ID    = 3'd0,
		PH_FLAG  = 3'd1,
		PH_COUNT = 3'd2,
		PH_RED   = 3'd3,
		PH_GREEN = 3'd4,
		PH_BLUE  = 3'd5
	} phase_t;

	phase_t     phase_q, phase_d;
	scan_mode_t mode_q, mode_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] colour_q, colour_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  flag_q, flag_d;
	logic [7:0]  col_code_q, row_code_q;

	always_comb begin
		phase_d  = phase_q;
		mode_d   = mode_q;
		count_d  = count_q;
		colour_d = colour_q;
		id_d     = id_q;
		flag_d   = flag_q;
		cmd      = '0;
		cmd_push = 1'b0;
		if (accept) begin
			if (item.op == OP_READ) begin
				cmd.do_read      = 1'b1;
				cmd.read_address = item.read_address;
				cmd_push         = 1'b1;
			end else begin
				case (phase_q)
					PH_ID: begin
						id_d    = item.data_byte;
						flag_d  = 8'd0;
						phase_d = PH_FLAG;
					end
					PH_FLAG: begin
						flag_d = item.data_byte;
						if (item.data_byte == col_code_q)
							mode_d = SCAN_COLUMN;
						else if (item.data_byte == row_code_q)
							mode_d = SCAN_ROW;
						else
							mode_d = SCAN_NONE;
						phase_d = PH_COUNT;
					end
					PH_COUNT: begin
						count_d = item.data_byte;
						phase_d = PH_RED;
					end
					PH_RED: begin
						colour_d = {item.data_byte, 8'd0};
						phase_d  = PH_GREEN;
					end
					PH_GREEN: begin
						colour_d[7:0] = item.data_byte;
						phase_d       = PH_BLUE;
					end
					default: begin
						phase_d    = PH_COUNT;
						cmd.do_run = (mode_q != SCAN_NONE);
					end
				endcase
				cmd.mode        = mode_d;
				cmd.run_count   = count_q;
				cmd.rgb         = {colour_q, item.data_byte};
				cmd.packet_id   = id_d;
				cmd.packet_flag = flag_d;
				cmd.do_status   = item.last_byte;
				cmd_push        = cmd.do_run | item.last_byte;
				if (item.last_byte) begin
					phase_d  = PH_ID;
					mode_d   = SCAN_NONE;
					count_d  = 8'd0;
					colour_d = 16'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ID;
			mode_q     <= SCAN_NONE;
			count_q    <= 8'd0;
			colour_q   <= 16'd0;
			id_q       <= 8'd0;
			flag_q     <= 8'd0;
			col_code_q <= 8'd0;
			row_code_q <= 8'd1;
		end else begin
			phase_q  <= phase_d;
			mode_q   <= mode_d;
			count_q  <= count_d;
			colour_q <= colour_d;
			id_q     <= id_d;
			flag_q   <= flag_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_COLUMN_CODE: col_code_q <= cfg_data;
					REG_ROW_CODE:    row_code_q <= cfg_data;
					default:         ;
				endcase
			end
		end
	end

endmodule

### rtl/rrfd_cmd_fifo.sv
module rrfd_cmd_fifo import rrfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_q, rd_q;
	logic [CMDQ_AW:0]   cnt_q;
	logic               do_push, do_pop;

	assign full    = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/rrfd_back.sv
module rrfd_back import rrfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RUN  = 2'd1,
		ST_FIN  = 2'd2,
		ST_READ = 2'd3
	} state_t;

	state_t            state_q;
	cmd_t              cur_q;
	logic [7:0]        cnt_q;
	logic [DONE_W-1:0] done_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              err_q;

	logic [23:0]       store [STORE_DEPTH];
	logic [23:0]       rd_data_q;

	result_t           oq_q [2];
	logic              owr_q, ord_q;
	logic [1:0]        ocnt_q;

	logic [LIN_W-1:0]  lin;
	logic              mem_we, mem_re, room, can_run, last_pix;
	logic              status_push, fin_done, out_push, out_pop;
	result_t           out_entry;

	assign lin      = LIN_W'(row_q) * LIN_W'(FRAME_WIDTH) + LIN_W'(col_q);
	assign mem_we   = (state_q == ST_RUN) && (lin < LIN_W'(STORE_DEPTH));
	assign room     = (ocnt_q != 2'd2);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid && (!cmd.do_read || room);
	assign mem_re   = cmd_pop && cmd.do_read;
	assign can_run  = cmd.do_run && (cmd.mode != SCAN_NONE) && !err_q
		&& (done_q < DONE_W'(FRAME_TOTAL));
	assign last_pix = (cnt_q == 8'd1) || (done_q == DONE_W'(FRAME_TOTAL - 1));

	assign status_push = (state_q == ST_FIN) && cur_q.do_status && room;
	assign fin_done    = (state_q == ST_FIN) && (!cur_q.do_status || room);
	assign out_push    = status_push || (state_q == ST_READ);
	assign out_pop     = pop && (ocnt_q != 2'd0);
	assign empty       = (ocnt_q == 2'd0);
	assign result      = oq_q[ord_q];

	always_comb begin
		out_entry = '0;
		if (state_q == ST_READ) begin
			out_entry.result_kind = KIND_PIXEL;
			out_entry.red_value   = rd_data_q[23:16];
			out_entry.green_value = rd_data_q[15:8];
			out_entry.blue_value  = rd_data_q[7:0];
		end else begin
			out_entry.result_kind = KIND_STATUS;
			out_entry.packet_id   = cur_q.packet_id;
			out_entry.packet_flag = cur_q.packet_flag;
			out_entry.frame_ok    = (cur_q.mode != SCAN_NONE) && !err_q
				&& (done_q == DONE_W'(FRAME_TOTAL));
		end
	end

	// frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			store[lin[ADDR_W-1:0]] <= cur_q.rgb;
		if (mem_re)
			rd_data_q <= store[cmd.read_address];
	end

	always_ff @(posedge clk) begin
		if (out_push)
			oq_q[owr_q] <= out_entry;
		if (cmd_pop)
			cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 8'd0;
			done_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			err_q   <= 1'b0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.do_read) begin
							state_q <= ST_READ;
						end else if (can_run && cmd.run_count == 8'd0) begin
							err_q   <= 1'b1;
							state_q <= ST_FIN;
						end else if (can_run) begin
							cnt_q   <= cmd.run_count;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RUN: begin
					done_q <= done_q + 1'b1;
					cnt_q  <= cnt_q - 8'd1;
					if (cur_q.mode == SCAN_COLUMN) begin
						if (row_q == ROW_W'(FRAME_HEIGHT - 1)) begin
							row_q <= '0;
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						if (col_q == COL_W'(FRAME_WIDTH - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
					if (last_pix)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_done) begin
						if (cur_q.do_status) begin
							done_q <= '0;
							col_q  <= '0;
							row_q  <= '0;
							err_q  <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_push)
				owr_q <= ~owr_q;
			if (out_pop)
				ord_q <= ~ord_q;
			case ({out_push, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

### rtl/rrfd_checker.sv
module rrfd_checker import rrfd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input in_item_t   item,
	input logic       empty,
	input logic       pop,
	input result_t    result,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input cfg_reg_t   cfg_index,
	input logic [7:0] cfg_data
);

	a_status_no_colour: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == KIND_STATUS) |->
		(result.red_value == 8'd0 && result.green_value == 8'd0 && result.blue_value == 8'd0))
		else $error("status beat carries colour");

	a_pixel_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == KIND_PIXEL) |->
		(result.packet_id == 8'd0 && result.packet_flag == 8'd0 && !result.frame_ok))
		else $error("pixel beat carries header fields");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	a_flags_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty, cfg_ready}))
		else $error("handshake flag unknown");

endmodule

bind rle_rgb_frame_decoder rrfd_checker u_rrfd_checker (.*);

### dv/tb_rle_rgb_frame_decoder.sv
module tb_rle_rgb_frame_decoder;
	import rrfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 1100;
	localparam int TAIL_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RAND_BEATS    = 110;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       full;
	in_item_t   item      = '0;
	logic       empty;
	logic       pop       = 1'b0;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_reg_t   cfg_index = REG_COLUMN_CODE;
	logic [7:0] cfg_data  = 8'h00;

	rle_rgb_frame_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder shadow
	logic [23:0] frame_shadow [STORE_DEPTH];
	int          pk_phase;
	logic [7:0]  run_len;
	logic [15:0] red_green;
	int          px_done;
	int          col_pos;
	int          row_pos;
	scan_mode_t  scan;
	logic [7:0]  cur_id;
	logic [7:0]  cur_flag;
	bit          zero_run_seen;
	logic [7:0]  col_code = 8'h00;
	logic [7:0]  row_code = 8'h01;

	in_item_t    pending_beats [$];
	result_t     expected_results [$];
	logic [7:0]  pkt_bytes [$];
	result_t     oldest;

	bit          bursts_on = 1'b1;
	int          send_gap;
	int          rcv_gap;
	int          errors;
	int          cycles;
	int          n_beats;
	int          n_status;
	int          n_frames_ok;
	int          n_reads;
	int          n_settings = 1;

	task automatic decode_beat(input in_item_t it);
		result_t    r;
		logic [23:0] px;
		int         i;
		int         addr;
		r = '0;
		if (it.op == OP_READ) begin
			px = frame_shadow[it.read_address];
			r.result_kind = KIND_PIXEL;
			r.red_value   = px[23:16];
			r.green_value = px[15:8];
			r.blue_value  = px[7:0];
			expected_results.push_back(r);
			return;
		end
		case (pk_phase)
			0: begin
				cur_id   = it.data_byte;
				cur_flag = 8'h00;
				pk_phase = 1;
			end
			1: begin
				cur_flag = it.data_byte;
				if (it.data_byte == col_code)
					scan = SCAN_COLUMN;
				else if (it.data_byte == row_code)
					scan = SCAN_ROW;
				else
					scan = SCAN_NONE;
				pk_phase = 2;
			end
			2: begin
				run_len  = it.data_byte;
				pk_phase = 3;
			end
			3: begin
				red_green = {it.data_byte, 8'h00};
				pk_phase  = 4;
			end
			4: begin
				red_green[7:0] = it.data_byte;
				pk_phase       = 5;
			end
			default: begin
				pk_phase = 2;
				if (scan != SCAN_NONE && !zero_run_seen && px_done < FRAME_TOTAL) begin
					if (run_len == 8'h00)
						zero_run_seen = 1'b1;
					for (i = 0; i < run_len && px_done < FRAME_TOTAL; i++) begin
						addr = row_pos * FRAME_WIDTH + col_pos;
						if (addr < STORE_DEPTH)
							frame_shadow[addr[ADDR_W-1:0]] = {red_green, it.data_byte};
						px_done++;
						if (scan == SCAN_COLUMN) begin
							row_pos++;
							if (row_pos >= FRAME_HEIGHT) begin
								row_pos = 0;
								col_pos++;
							end
						end else begin
							col_pos++;
							if (col_pos >= FRAME_WIDTH) begin
								col_pos = 0;
								row_pos++;
							end
						end
					end
				end
			end
		endcase
		if (it.last_byte) begin
			r.result_kind = KIND_STATUS;
			r.packet_id   = cur_id;
			r.packet_flag = cur_flag;
			r.frame_ok    = scan != SCAN_NONE && !zero_run_seen && px_done == FRAME_TOTAL;
			expected_results.push_back(r);
			pk_phase      = 0;
			run_len       = 8'h00;
			red_green     = 16'h0000;
			px_done       = 0;
			col_pos       = 0;
			row_pos       = 0;
			scan          = SCAN_NONE;
			zero_run_seen = 1'b0;
		end
	endtask

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push     <= 1'b0;
			item     <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full)
				decode_beat(item);
			if (!push || !full) begin
				if (send_gap != 0) begin
					push     <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_beats.size() != 0) begin
					item <= pending_beats.pop_front();
					push <= 1'b1;
					if (bursts_on && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 12);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop     <= 1'b0;
			rcv_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					if (oldest.result_kind == KIND_PIXEL)
						n_reads++;
					else begin
						n_status++;
						if (oldest.frame_ok)
							n_frames_ok++;
					end
					cmp_field("result_kind", 8'(oldest.result_kind), 8'(result.result_kind));
					cmp_field("packet_id", oldest.packet_id, result.packet_id);
					cmp_field("packet_flag", oldest.packet_flag, result.packet_flag);
					cmp_field("frame_ok", 8'(oldest.frame_ok), 8'(result.frame_ok));
					cmp_field("red_value", oldest.red_value, result.red_value);
					cmp_field("green_value", oldest.green_value, result.green_value);
					cmp_field("blue_value", oldest.blue_value, result.blue_value);
				end
			end
			if (rcv_gap != 0) begin
				pop     <= 1'b0;
				rcv_gap <= rcv_gap - 1;
			end else if (bursts_on && $urandom_range(0, 9) == 0) begin
				pop     <= 1'b0;
				rcv_gap <= $urandom_range(0, 11);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[rle_rgb_frame_decoder] ERROR");
			$finish;
		end
	end

	function automatic void queue_beat(input logic op, input logic [7:0] b, input logic last,
		input logic [ADDR_W-1:0] addr);
		in_item_t it;
		it.op           = op;
		it.data_byte    = b;
		it.last_byte    = last;
		it.read_address = addr;
		pending_beats.push_back(it);
		n_beats++;
	endfunction

	function automatic void queue_read(input logic [ADDR_W-1:0] addr);
		queue_beat(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), addr);
	endfunction

	function automatic void stage_quad(input logic [7:0] cnt, input logic [23:0] rgb);
		pkt_bytes.push_back(cnt);
		pkt_bytes.push_back(rgb[23:16]);
		pkt_bytes.push_back(rgb[15:8]);
		pkt_bytes.push_back(rgb[7:0]);
	endfunction

	// sends staged bytes as one packet, reads sprinkled in at read_pct percent
	function automatic void flush_packet(input int read_pct);
		int i;
		for (i = 0; i < pkt_bytes.size(); i++) begin
			if ($urandom_range(0, 99) < read_pct)
				queue_read(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
			queue_beat(OP_PACKET, pkt_bytes[i], i == pkt_bytes.size() - 1,
				ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
		end
		pkt_bytes.delete();
	endfunction

	function automatic void queue_random_packet();
		int         sel;
		int         style;
		int         left;
		int         n;
		int         i;
		logic [7:0] cnt;
		logic [7:0] flag;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			flag = col_code;
		else if (sel < 8)
			flag = row_code;
		else
			flag = 8'($urandom_range(0, 255));
		style = $urandom_range(0, 9);
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		if (style != 0)
			pkt_bytes.push_back(flag);
		if (style >= 2 && style <= 5) begin
			left = FRAME_TOTAL;
			while (left > 0) begin
				cnt = 8'($urandom_range(96, 255));
				if (cnt > left && $urandom_range(0, 1) == 0)
					cnt = 8'(left);
				stage_quad(cnt, 24'($urandom));
				left -= cnt;
			end
			n = $urandom_range(0, 2);
			for (i = 0; i < n; i++)
				stage_quad($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(1, 255)),
					24'($urandom));
		end else if (style >= 6) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				if (style == 9 && i == n / 2)
					cnt = 8'h00;
				else
					cnt = 8'($urandom_range(0, 255));
				stage_quad(cnt, 24'($urandom));
			end
		end
		if (style != 0 && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++)
				pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end
		flush_packet(8);
		if ($urandom_range(0, 3) == 0)
			queue_read(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
	endfunction

	task automatic drain(input bit settle);
		while (pending_beats.size() != 0 || push || expected_results.size() != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COLUMN_CODE: col_code = val;
			REG_ROW_CODE:    row_code = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] col_set [4];
		logic [7:0] row_set [4];
		int         ph;
		int         target;
		int         i;
		col_set = '{8'hFF, 8'h07, 8'h00, 8'h00};
		row_set = '{8'h00, 8'h07, 8'hFF, 8'h00};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every pixel row-major, then quads past the full frame
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'h01);
		for (i = 0; i < 16; i++)
			stage_quad(8'hFF, 24'($urandom));
		stage_quad(8'd16, 24'h123456);
		stage_quad(8'h00, 24'hFFFFFF);
		stage_quad(8'hFF, 24'h000000);
		flush_packet(0);
		queue_read(12'h000);
		queue_read(12'hFFF);
		queue_read(12'hAAA);
		queue_read(12'h555);

		// column-major run ending in a lone count byte
		pkt_bytes.push_back(8'hFF);
		pkt_bytes.push_back(8'h00);
		stage_quad(8'hFF, 24'hFFFFFF);
		stage_quad(8'h01, 24'h000000);
		pkt_bytes.push_back(8'h05);
		flush_packet(0);
		queue_read(12'h000);
		queue_read(12'h040);
		queue_read(12'h001);
		queue_read(12'h0FF);

		pkt_bytes.push_back(8'h5A);
		flush_packet(0);
		pkt_bytes.push_back(8'h33);
		pkt_bytes.push_back(8'h01);
		flush_packet(0);
		pkt_bytes.push_back(8'hC3);
		pkt_bytes.push_back(8'h80);
		stage_quad(8'd10, 24'hA5A5A5);
		flush_packet(0);

		// zero count mid-packet, followed by two reads
		queue_beat(OP_PACKET, 8'h77, 1'b0, 12'h000);
		queue_beat(OP_PACKET, 8'h01, 1'b0, 12'hFFF);
		pkt_bytes.push_back(8'h03);
		pkt_bytes.push_back(8'h11);
		pkt_bytes.push_back(8'h22);
		pkt_bytes.push_back(8'h33);
		stage_quad(8'h00, 24'h445566);
		stage_quad(8'h04, 24'h778899);
		for (i = 0; i < pkt_bytes.size(); i++)
			queue_beat(OP_PACKET, pkt_bytes[i], i == pkt_bytes.size() - 1, 12'h000);
		pkt_bytes.delete();
		queue_read(12'h001);
		queue_read(12'h003);
		drain(0);

		for (ph = 0; ph < 4; ph++) begin
			drain(1);
			if (ph == 3) begin
				bursts_on = 1'b0;
				col_set[ph] = 8'($urandom_range(0, 255));
				row_set[ph] = 8'($urandom_range(0, 255));
			end
			write_reg(REG_COLUMN_CODE, col_set[ph]);
			write_reg(REG_ROW_CODE, row_set[ph]);
			n_settings++;
			target = n_beats + RAND_BEATS;
			while (n_beats < target) begin
				queue_random_packet();
				if ($urandom_range(0, 5) == 0)
					drain(0);
			end
		end

		drain(0);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d beats sent under %0d flag code settings, in %0d cycles",
			n_beats, n_settings, cycles);
		$display("%0d packet status beats (%0d full frames), %0d pixel reads checked",
			n_status, n_frames_ok, n_reads);
		if (errors == 0)
			$display("[rle_rgb_frame_decoder] OK");
		else
			$display("[rle_rgb_frame_decoder] ERROR");
		$finish;
	end

endmodule

### rle_rgb_frame_decoder.f
rtl/rrfd_pkg.sv
rtl/rrfd_front.sv
rtl/rrfd_cmd_fifo.sv
rtl/rrfd_back.sv
rtl/rle_rgb_frame_decoder.sv
rtl/rrfd_checker.sv
dv/tb_rle_rgb_frame_decoder.sv
